// ===== rtl/core/pip_pkg.sv =====
// shared constants, codes and controller/datapath interface types for the polygon test unit
`timescale 1ns / 1ps
`default_nettype none

package pip_pkg;

    localparam int MAX_VERTICES = 16;
    localparam int COORD_WIDTH  = 16;

    localparam int IDX_W  = $clog2(MAX_VERTICES);
    localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
    localparam int VTX_W  = 2 * COORD_WIDTH;
    localparam int DIFF_W = COORD_WIDTH + 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int SUM_W  = PROD_W + 1;

    localparam logic [1:0] CMD_APPEND = 2'd0;
    localparam logic [1:0] CMD_QUERY  = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic             start_query;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic             rd_en;
        logic             rd_first;
        logic [IDX_W-1:0] rd_addr;
        logic             close_edge;
        logic             load_out;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_busy;
    } t_dp_sts;

endpackage

`default_nettype wire

// ===== rtl/core/point_in_polygon_test_unit.sv =====
// top level of the point-in-polygon ray crossing unit
// commands: append, clear and unknown commands are taken in idle and leave the block
//   ready; a query walks the stored vertices, then loads its result (at once when empty)
// a new query is taken only after the last one has loaded its result; the walk is set by the
//   single vertex ram read port reading one vertex per cycle plus the 3-stage edge pipeline
// reset: synchronous active-low i_rst_n empties the polygon and drops any pending
//   result; vertex ram contents are not cleared and need no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module point_in_polygon_test_unit (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    // input channel
    input  wire logic                                   i_valid,
    output logic                                        o_ready,
    input  wire logic [1:0]                             i_cmd,
    input  wire logic signed [pip_pkg::COORD_WIDTH-1:0] i_x_coord,
    input  wire logic signed [pip_pkg::COORD_WIDTH-1:0] i_y_coord,
    // result channel
    output logic                                        o_valid,
    input  wire logic                                   i_ready,
    output logic                                        o_inside_res
);

    // command and status between sequencer and datapath
    pip_pkg::t_dp_cmd w_dp_cmd;
    pip_pkg::t_dp_sts w_dp_sts;

    // controller owns vertex count and edge walk; an input transaction is taken
    // only while it is idle, and a held result stalls only a later query that
    // is ready to load its own result, which then holds off further input
    pip_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_cmd   (i_cmd),
        .o_ready (o_ready),
        .i_sts   (w_dp_sts),
        .o_cmd   (w_dp_cmd)
    );

    // datapath: vertex ram, exact cross-multiply edge test, left/right parity
    // and the output register that holds one result transaction
    pip_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_x_coord    (i_x_coord),
        .i_y_coord    (i_y_coord),
        .i_cmd        (w_dp_cmd),
        .o_sts        (w_dp_sts),
        .i_out_ready  (i_ready),
        .o_valid      (o_valid),
        .o_inside_res (o_inside_res)
    );

`ifndef NO_ASSERTIONS
    // a query keeps the block busy on the following cycle
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && (i_cmd == pip_pkg::CMD_QUERY)) |=> !o_ready)
        else $error("input accepted right after a query");

    // a result is loaded only into a free output register
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_dp_cmd.load_out |-> (!o_valid || i_ready))
        else $error("result overwrote a pending transaction");

    // a new result appears only after a load command
    a_valid_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(w_dp_cmd.load_out))
        else $error("result valid without load");

    // ram writes and edge walk reads never overlap
    a_rw_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_dp_cmd.wr_en && (w_dp_cmd.rd_en || w_dp_cmd.close_edge)))
        else $error("vertex write during edge walk");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/pip_ram.sv =====
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module pip_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== rtl/core/pip_ctrl.sv =====
// controller: command decode, vertex count and edge walk sequencing
`timescale 1ns / 1ps
`default_nettype none

module pip_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic [1:0]        i_cmd,
    output logic                   o_ready,
    input  wire pip_pkg::t_dp_sts  i_sts,
    output pip_pkg::t_dp_cmd       o_cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_RUN   = 3'd1;
    localparam logic [2:0] ST_CLOSE = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_FIN   = 3'd4;

    logic [2:0]                  r_state, n_state;
    logic [pip_pkg::CNT_W-1:0]   r_count, n_count;
    logic [pip_pkg::IDX_W-1:0]   r_addr,  n_addr;
    logic [1:0]                  r_drain, n_drain;
    logic                        w_accept;
    logic                        w_last;

    assign o_ready  = (r_state == ST_IDLE);
    assign w_accept = i_valid && o_ready;
    assign w_last   = ({{(pip_pkg::CNT_W - pip_pkg::IDX_W){1'b0}}, r_addr}
                       == (r_count - pip_pkg::CNT_W'(1)));

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_addr  = r_addr;
        n_drain = r_drain;

        o_cmd             = '0;
        o_cmd.wr_addr     = r_count[pip_pkg::IDX_W-1:0];
        o_cmd.rd_addr     = r_addr;
        o_cmd.rd_first    = (r_addr == '0);

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    case (i_cmd)
                        pip_pkg::CMD_APPEND: begin
                            if (r_count < pip_pkg::CNT_W'(pip_pkg::MAX_VERTICES)) begin
                                o_cmd.wr_en = 1'b1;
                                n_count     = r_count + pip_pkg::CNT_W'(1);
                            end
                        end
                        pip_pkg::CMD_QUERY: begin
                            o_cmd.start_query = 1'b1;
                            n_addr            = '0;
                            n_state           = (r_count == '0) ? ST_FIN : ST_RUN;
                        end
                        pip_pkg::CMD_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_RUN: begin
                o_cmd.rd_en = 1'b1;
                if (w_last) begin
                    n_state = ST_CLOSE;
                end else begin
                    n_addr = r_addr + pip_pkg::IDX_W'(1);
                end
            end
            ST_CLOSE: begin
                o_cmd.close_edge = 1'b1;
                n_drain          = 2'd2;
                n_state          = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (r_drain == 2'd0) begin
                    n_state = ST_FIN;
                end else begin
                    n_drain = r_drain - 2'd1;
                end
            end
            ST_FIN: begin
                if (!i_sts.out_busy) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_addr  <= '0;
            r_drain <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_addr  <= n_addr;
            r_drain <= n_drain;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/pip_dp.sv =====
// datapath: vertex ram, edge pipeline, crossing parity and result register
`timescale 1ns / 1ps
`default_nettype none

module pip_dp (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic signed [pip_pkg::COORD_WIDTH-1:0] i_x_coord,
    input  wire logic signed [pip_pkg::COORD_WIDTH-1:0] i_y_coord,
    input  wire pip_pkg::t_dp_cmd                       i_cmd,
    output pip_pkg::t_dp_sts                            o_sts,
    input  wire logic                                   i_out_ready,
    output logic                                        o_valid,
    output logic                                        o_inside_res
);

    localparam int CW = pip_pkg::COORD_WIDTH;
    localparam int DW = pip_pkg::DIFF_W;
    localparam int PW = pip_pkg::PROD_W;
    localparam int SW = pip_pkg::SUM_W;

    // edge classes
    localparam logic [1:0] EC_SKIP  = 2'd0;
    localparam logic [1:0] EC_END   = 2'd1;
    localparam logic [1:0] EC_VERT  = 2'd2;
    localparam logic [1:0] EC_CROSS = 2'd3;

    logic [pip_pkg::VTX_W-1:0] w_rd_data;

    pip_ram #(
        .WIDTH (pip_pkg::VTX_W),
        .DEPTH (pip_pkg::MAX_VERTICES)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.wr_en),
        .i_wr_addr (i_cmd.wr_addr),
        .i_wr_data ({i_x_coord, i_y_coord}),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (i_cmd.rd_addr),
        .o_rd_data (w_rd_data)
    );

    logic signed [CW-1:0] r_px, r_py;

    // stage 0: ram read tags
    logic r_s0_vld, r_s0_first, r_s0_close;

    // stage 1: edge setup
    logic signed [CW-1:0] r_first_x, r_first_y, r_prev_x, r_prev_y;
    logic signed [CW-1:0] w_x0, w_y0, w_x1, w_y1;
    logic [1:0]           w_class;
    logic                 w_hit, w_left;
    logic signed [DW-1:0] w_a, w_dy, w_t, w_dx;

    logic                 r_s1_vld;
    logic [1:0]           r_s1_class;
    logic                 r_s1_hit, r_s1_left;
    logic signed [DW-1:0] r_s1_a, r_s1_dy, r_s1_t, r_s1_dx;

    // stage 2: products
    logic                 r_s2_vld;
    logic [1:0]           r_s2_class;
    logic                 r_s2_hit, r_s2_left, r_s2_neg;
    logic signed [PW-1:0] r_s2_p1, r_s2_p2;

    // stage 3: count update
    logic signed [SW-1:0] w_sum;
    logic                 w_upd_hit, w_upd_left, w_upd_right;
    logic                 r_hit, r_left, r_right;

    logic r_out_valid, r_out_res;

    assign w_x0 = r_prev_x;
    assign w_y0 = r_prev_y;
    assign w_x1 = r_s0_close ? r_first_x : $signed(w_rd_data[pip_pkg::VTX_W-1:CW]);
    assign w_y1 = r_s0_close ? r_first_y : $signed(w_rd_data[CW-1:0]);

    always_comb begin
        w_a  = DW'(w_x0) - DW'(r_px);
        w_dy = DW'(w_y1) - DW'(w_y0);
        w_t  = DW'(r_py) - DW'(w_y0);
        w_dx = DW'(w_x1) - DW'(w_x0);

        w_hit  = 1'b0;
        w_left = 1'b0;
        if (((w_y0 < r_py) && (w_y1 < r_py)) || ((w_y0 > r_py) && (w_y1 > r_py))
                || (w_y0 == r_py)) begin
            w_class = EC_SKIP;
        end else if (w_y1 == r_py) begin
            w_class = EC_END;
            w_hit   = (r_px == w_x1);
            w_left  = (r_px > w_x1);
        end else if (w_x0 == w_x1) begin
            w_class = EC_VERT;
            w_left  = (w_x0 < r_px);
        end else begin
            w_class = EC_CROSS;
        end
    end

    // sign of the cross product places the crossing left or right of the point
    assign w_sum = SW'(r_s2_p1) + SW'(r_s2_p2);

    always_comb begin
        w_upd_hit   = 1'b0;
        w_upd_left  = 1'b0;
        w_upd_right = 1'b0;
        if (r_s2_vld) begin
            case (r_s2_class)
                EC_END, EC_VERT: begin
                    w_upd_hit   = r_s2_hit;
                    w_upd_left  = !r_s2_hit && r_s2_left;
                    w_upd_right = !r_s2_hit && !r_s2_left;
                end
                EC_CROSS: begin
                    w_upd_hit   = (w_sum == '0);
                    w_upd_left  = (w_sum != '0) && ((w_sum < 0) ^ r_s2_neg);
                    w_upd_right = (w_sum != '0) && !((w_sum < 0) ^ r_s2_neg);
                end
                default: begin
                end
            endcase
        end
    end

    // control flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld    <= 1'b0;
            r_s0_first  <= 1'b0;
            r_s0_close  <= 1'b0;
            r_s1_vld    <= 1'b0;
            r_s2_vld    <= 1'b0;
            r_hit       <= 1'b0;
            r_left      <= 1'b0;
            r_right     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s0_vld   <= i_cmd.rd_en || i_cmd.close_edge;
            r_s0_first <= i_cmd.rd_en && i_cmd.rd_first;
            r_s0_close <= i_cmd.close_edge;
            r_s1_vld   <= r_s0_vld && !r_s0_first;
            r_s2_vld   <= r_s1_vld;
            if (i_cmd.start_query) begin
                r_hit   <= 1'b0;
                r_left  <= 1'b0;
                r_right <= 1'b0;
            end else begin
                r_hit   <= r_hit | w_upd_hit;
                r_left  <= r_left ^ w_upd_left;
                r_right <= r_right ^ w_upd_right;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.start_query) begin
            r_px <= i_x_coord;
            r_py <= i_y_coord;
        end
        if (r_s0_vld) begin
            if (r_s0_first) begin
                r_first_x <= w_x1;
                r_first_y <= w_y1;
            end
            r_prev_x <= w_x1;
            r_prev_y <= w_y1;
        end
        r_s1_class <= w_class;
        r_s1_hit   <= w_hit;
        r_s1_left  <= w_left;
        r_s1_a     <= w_a;
        r_s1_dy    <= w_dy;
        r_s1_t     <= w_t;
        r_s1_dx    <= w_dx;

        r_s2_class <= r_s1_class;
        r_s2_hit   <= r_s1_hit;
        r_s2_left  <= r_s1_left;
        r_s2_neg   <= (r_s1_dy < 0);
        r_s2_p1    <= PW'(r_s1_a) * PW'(r_s1_dy);
        r_s2_p2    <= PW'(r_s1_t) * PW'(r_s1_dx);

        if (i_cmd.load_out) begin
            r_out_res <= r_hit | (r_left & r_right);
        end
    end

    assign o_sts.out_busy = r_out_valid && !i_out_ready;
    assign o_valid        = r_out_valid;
    assign o_inside_res   = r_out_res;

endmodule

`default_nettype wire
